>>> hw/rtl/tts_pkg.sv
// Shared types, codes and defaults for the task timer table scheduler.
`default_nettype none
package tts_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int TIME_BITS_DEF  = 32;

    // request kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_POLL    = 3'd1;
    localparam logic [2:0] KIND_REG     = 3'd2;
    localparam logic [2:0] KIND_DEREG   = 3'd3;
    localparam logic [2:0] KIND_SCHED   = 3'd4;
    localparam logic [2:0] KIND_RESCHED = 3'd5;
    localparam logic [2:0] KIND_UNSCHED = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_FREE = 2'd1;
    localparam logic [1:0] ERR_OVER    = 2'd2;

    // register index 0: ticks_per_clock
    localparam logic REG_TPC = 1'b0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] task_id;
        logic [31:0] delay_ms;
        logic [15:0] task_param;
    } t_req;

    typedef struct packed {
        logic        fired;
        logic [15:0] fired_id;
        logic [15:0] fired_param;
        logic [1:0]  error;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POLL,
        ST_REG,
        ST_REG_WR,
        ST_SRCH,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic tick;
        logic poll_read;
        logic poll_fire;
        logic free_next;
        logic free_read;
        logic no_free;
        logic reg_write;
        logic scan_step;
        logic apply;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       free;
        logic       last;
        logic       hit;
        logic       miss_end;
    } t_stat;

endpackage
`default_nettype wire

>>> hw/rtl/tts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/tts_ctrl.sv
// Controller state machine: sequences table walks and result strobes.
`default_nettype none
module tts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire tts_pkg::t_stat i_stat,
    output logic               o_busy,
    output tts_pkg::t_cmd      o_cmd
);
    import tts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.kind)
                    KIND_TICK: begin
                        o_cmd.tick   = 1'b1;
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                    KIND_POLL: begin
                        o_cmd.poll_read = 1'b1;
                        n_state         = ST_POLL;
                    end
                    KIND_REG: begin
                        n_state = ST_REG;
                    end
                    KIND_DEREG, KIND_SCHED, KIND_RESCHED, KIND_UNSCHED: begin
                        n_state = ST_SRCH;
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                endcase
            end
            ST_POLL: begin
                o_cmd.poll_fire = 1'b1;
                o_cmd.finish    = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_REG: begin
                if (i_stat.free) begin
                    o_cmd.free_read = 1'b1;
                    n_state         = ST_REG_WR;
                end else if (i_stat.last) begin
                    o_cmd.no_free = 1'b1;
                    o_cmd.finish  = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    o_cmd.free_next = 1'b1;
                end
            end
            ST_REG_WR: begin
                o_cmd.reg_write = 1'b1;
                o_cmd.finish    = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SRCH: begin
                if (i_stat.hit) begin
                    n_state = ST_APPLY;
                end else if (i_stat.miss_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_APPLY: begin
                o_cmd.apply  = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

>>> hw/rtl/tts_dp.sv
// Datapath: slot table, flags, prescaler, clock, pointer and result register.
`default_nettype none
module tts_dp #(
    parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF,
    parameter int TIME_BITS  = tts_pkg::TIME_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tts_pkg::t_req i_req,
    input  wire logic [15:0]   i_ticks_per_clock,
    input  wire tts_pkg::t_cmd i_cmd,
    output tts_pkg::t_stat     o_stat,
    output logic               o_res_valid,
    output tts_pkg::t_res      o_res
);
    import tts_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int T  = TIME_BITS;
    localparam int EW = 16 + T + T + 16;   // {id, delay, due, param}

    t_req             r_req;
    t_res             r_res;
    logic             r_res_valid;
    logic [CW-1:0]    r_addr;
    logic             r_pend_v;
    logic [IW-1:0]    r_pend_idx;
    logic             r_rd_ok;
    logic [SLOT_COUNT-1:0] r_valid;
    logic [SLOT_COUNT-1:0] r_alloc;
    logic [SLOT_COUNT-1:0] r_sched;
    logic [T-1:0]     r_clock;
    logic [15:0]      r_presc;
    logic [IW-1:0]    r_ptr;
    logic [7:0]       r_total;

    logic [IW-1:0]    addr_idx;
    logic             addr_in_range;
    logic             ram_we;
    logic             ram_re;
    logic [IW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_wdata;
    logic [EW-1:0]    ram_rdata;
    logic [EW-1:0]    rd_ent;
    logic [15:0]      rd_id;
    logic [T-1:0]     rd_delay;
    logic [T-1:0]     rd_due;
    logic [15:0]      rd_param;
    logic [T-1:0]     req_delay;
    logic [T-1:0]     due_src;
    logic [T:0]       due_sum;
    logic [T-1:0]     n_due;
    logic [15:0]      n_presc;
    logic [7:0]       n_total;
    logic             id_hit;
    logic             poll_due;

    assign addr_idx      = r_addr[IW-1:0];
    assign addr_in_range = (r_addr < CW'(SLOT_COUNT));

    // entries never written read as zero
    assign rd_ent   = r_rd_ok ? ram_rdata : '0;
    assign rd_id    = rd_ent[EW-1 -: 16];
    assign rd_delay = rd_ent[T+T+15 -: T];
    assign rd_due   = rd_ent[T+15 -: T];
    assign rd_param = rd_ent[15:0];

    assign req_delay = T'(r_req.delay_ms);
    assign id_hit    = r_pend_v && (rd_id == r_req.task_id);
    assign poll_due  = r_alloc[r_ptr] && r_sched[r_ptr] && (r_clock >= rd_due);

    // due = clock + delay, with one extra count when the sum wraps
    assign due_src = (r_req.kind == KIND_SCHED) ? req_delay : rd_delay;
    assign due_sum = {1'b0, r_clock} + {1'b0, due_src};
    assign n_due   = due_sum[T] ? (due_sum[T-1:0] + T'(1)) : due_sum[T-1:0];

    assign n_presc = r_presc + 16'd1;
    assign n_total = r_total + 8'd1;

    assign ram_re    = i_cmd.poll_read || i_cmd.free_read ||
                       (i_cmd.scan_step && addr_in_range);
    assign ram_raddr = i_cmd.poll_read ? r_ptr : addr_idx;
    assign ram_we    = i_cmd.reg_write || (i_cmd.apply && (r_req.kind != KIND_DEREG));

    always_comb begin
        ram_wdata = rd_ent;
        if (i_cmd.reg_write) begin
            ram_wdata = {r_req.task_id, rd_delay, rd_due, rd_param};
        end else begin
            case (r_req.kind)
                KIND_SCHED:   ram_wdata = {rd_id, req_delay, n_due, r_req.task_param};
                KIND_RESCHED: ram_wdata = {rd_id, rd_delay, n_due, r_req.task_param};
                KIND_UNSCHED: ram_wdata = {rd_id, rd_delay, {T{1'b0}}, 16'd0};
                default:      ram_wdata = rd_ent;
            endcase
        end
    end

    tts_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pend_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_res <= '0;
        end
        if (ram_re) begin
            r_rd_ok <= r_valid[ram_raddr];
        end
        if (i_cmd.free_read) begin
            r_pend_idx <= addr_idx;
        end
        if (i_cmd.scan_step && addr_in_range) begin
            r_pend_idx <= addr_idx;
        end
        if (i_cmd.poll_fire && poll_due) begin
            r_res.fired       <= 1'b1;
            r_res.fired_id    <= rd_id;
            r_res.fired_param <= rd_param;
        end
        if (i_cmd.no_free) begin
            r_res.error <= ERR_NO_FREE;
        end
        if (i_cmd.reg_write && (n_total > 8'(SLOT_COUNT))) begin
            r_res.error <= ERR_OVER;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_addr      <= '0;
            r_pend_v    <= 1'b0;
            r_valid     <= '0;
            r_alloc     <= '0;
            r_sched     <= '0;
            r_clock     <= '0;
            r_presc     <= '0;
            r_ptr       <= '0;
            r_total     <= '0;
        end else begin
            r_res_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_addr   <= '0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.free_next) begin
                r_addr <= r_addr + CW'(1);
            end
            if (i_cmd.scan_step) begin
                r_pend_v <= addr_in_range;
                if (addr_in_range) begin
                    r_addr <= r_addr + CW'(1);
                end
            end
            if (i_cmd.tick) begin
                if (n_presc == i_ticks_per_clock) begin
                    r_clock <= r_clock + T'(1);
                    r_presc <= '0;
                end else begin
                    r_presc <= n_presc;
                end
            end
            if (i_cmd.poll_fire) begin
                if (poll_due) begin
                    r_sched[r_ptr] <= 1'b0;
                end
                r_ptr <= (r_ptr == IW'(SLOT_COUNT - 1)) ? '0 : r_ptr + IW'(1);
            end
            if (i_cmd.reg_write) begin
                r_valid[r_pend_idx] <= 1'b1;
                r_alloc[r_pend_idx] <= 1'b1;
                r_total             <= n_total;
            end
            if (i_cmd.apply) begin
                case (r_req.kind)
                    KIND_DEREG: begin
                        r_valid[r_pend_idx] <= 1'b0;
                        r_alloc[r_pend_idx] <= 1'b0;
                        r_sched[r_pend_idx] <= 1'b0;
                        r_total             <= r_total - 8'd1;
                    end
                    KIND_SCHED, KIND_RESCHED: begin
                        r_valid[r_pend_idx] <= 1'b1;
                        r_sched[r_pend_idx] <= 1'b1;
                    end
                    KIND_UNSCHED: begin
                        r_valid[r_pend_idx] <= 1'b1;
                        r_sched[r_pend_idx] <= 1'b0;
                    end
                    default: begin
                        r_valid[r_pend_idx] <= r_valid[r_pend_idx];
                    end
                endcase
            end
        end
    end

    assign o_stat.kind     = r_req.kind;
    assign o_stat.free     = !r_alloc[addr_idx];
    assign o_stat.last     = (addr_idx == IW'(SLOT_COUNT - 1));
    assign o_stat.hit      = id_hit;
    assign o_stat.miss_end = r_pend_v && !id_hit && (r_pend_idx == IW'(SLOT_COUNT - 1));

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // every request ends in a single strobe with a decode cycle between
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |=> !r_res_valid)
        else $error("back-to-back result strobes");

    a_fire_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.fired) |-> (r_res.error == ERR_NONE))
        else $error("dispatch carries an error code");

    a_apply_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> id_hit)
        else $error("table update without a matching slot");

    a_reg_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.reg_write |-> !r_alloc[r_pend_idx])
        else $error("register overwrote an allocated slot");

endmodule
`default_nettype wire

>>> hw/rtl/task_timer_table_scheduler_unit.sv
// Top level of the task timer table scheduler: config register, controller, datapath.
`default_nettype none
// Usage
//   Request channel: drive i_req and raise i_start; the request is taken at a rising
//   edge where i_start is high and o_busy is low. o_busy stays high until the result.
//   Result channel: o_res is valid for exactly one cycle while o_res_valid is high.
//   Every request yields one result. The receiver cannot stall the block.
//   Config: APB port, ticks_per_clock at byte address 0 (low 16 bits), reset 1.
//   Write it only while no request is in flight.
// Sequence (accept edge to strobe cycle)
//   tick, unused kind: decode only. poll: decode, then the poll step.
//   register: decode, a walk of the allocated flags one a cycle to the lowest free slot,
//   then the slot write; or to the last slot when no slot is free.
//   deregister/schedule/reschedule/unschedule: decode, an ID walk of the slot RAM one
//   entry a cycle to the matching slot, then the update; or to the end on no match.
// Requests: the next request is taken in the strobe cycle; no new request is taken
//   while one is in flight.
// Reset: synchronous active low; clears the table flags, clock, prescaler, pointer and
//   task count. Slot words read as zero until written.
module task_timer_table_scheduler_unit #(
    parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF,
    parameter int TIME_BITS  = tts_pkg::TIME_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire tts_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_res_valid,
    output tts_pkg::t_res      o_res,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tts_pkg::*;

    logic [15:0] r_tpc;
    t_cmd        cmd;
    t_stat       stat;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpc <= 16'd1;
        end else if (cfg_wr && (paddr[2] == REG_TPC)) begin
            r_tpc <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_TPC) ? {16'd0, r_tpc} : 32'd0;

    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    tts_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (i_req),
        .i_ticks_per_clock (r_tpc),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_res_valid       (o_res_valid),
        .o_res             (o_res)
    );

endmodule
`default_nettype wire
